// File: hw/rtl/quintic_trajectory_generator_assert.svh
// ----------------------------------------------------------------------------
// quintic trajectory generator assertion macros
// concurrent checks clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef QUINTIC_TRAJECTORY_GENERATOR_ASSERT_SVH
`define QUINTIC_TRAJECTORY_GENERATOR_ASSERT_SVH

// condition must never hold
`define QTG_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define QTG_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/qtg_pkg.sv
// ----------------------------------------------------------------------------
// qtg_pkg
// shared types, constants, micro-program and helpers of the trajectory block
// ----------------------------------------------------------------------------
`default_nettype none

package qtg_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int COEF_W    = 64;
    localparam int MAG_W     = COEF_W - 1;
    localparam int DIV_W     = COEF_W + FRAC_BITS;
    localparam int MUL_W     = MAG_W + DATA_W;
    localparam int TERM_W    = 40;
    localparam int NUM_COEF  = 6;

    localparam logic signed [COEF_W-1:0] SAT_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] SAT_MIN = -SAT_MAX;

    // item kinds
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_SEG  = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [DATA_W-1:0] pos;
        logic signed [DATA_W-1:0] vel;
        logic signed [DATA_W-1:0] acc;
        logic [DATA_W-1:0]        duration;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] position;
        logic                     moving;
    } t_out;

    // micro-operations
    typedef enum logic [3:0] {
        OP_LDT, OP_DIV, OP_ADDT, OP_HST, OP_STEPS, OP_END_SEG,
        OP_LDC, OP_MUL, OP_ADDC, OP_END_TICK
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [3:0] arg;
    } t_uop;

    // segment term selects
    localparam logic [3:0] TRM_DS20  = 4'd0;
    localparam logic [3:0] TRM_NV3   = 4'd1;
    localparam logic [3:0] TRM_NA3   = 4'd2;
    localparam logic [3:0] TRM_NDS30 = 4'd3;
    localparam logic [3:0] TRM_V4    = 4'd4;
    localparam logic [3:0] TRM_A4    = 4'd5;
    localparam logic [3:0] TRM_DS12  = 4'd6;
    localparam logic [3:0] TRM_NV5   = 4'd7;
    localparam logic [3:0] TRM_NA5   = 4'd8;

    localparam int PROG_LEN = 38;
    localparam int PC_W     = $clog2(PROG_LEN);
    localparam logic [PC_W-1:0] PC_SEG   = PC_W'(0);
    localparam logic [PC_W-1:0] PC_STEPS = PC_W'(24);
    localparam logic [PC_W-1:0] PC_TICK  = PC_W'(26);

    // segment coefficients, step count, then tick horner evaluation
    localparam t_uop PROG [PROG_LEN] = '{
        '{OP_LDT, TRM_DS20}, '{OP_DIV, 4'd0}, '{OP_ADDT, TRM_NV3}, '{OP_DIV, 4'd0},
        '{OP_ADDT, TRM_NA3}, '{OP_DIV, 4'd0}, '{OP_HST, 4'd3},
        '{OP_LDT, TRM_NDS30}, '{OP_DIV, 4'd0}, '{OP_ADDT, TRM_V4}, '{OP_DIV, 4'd0},
        '{OP_ADDT, TRM_A4}, '{OP_DIV, 4'd0}, '{OP_DIV, 4'd0}, '{OP_HST, 4'd4},
        '{OP_LDT, TRM_DS12}, '{OP_DIV, 4'd0}, '{OP_ADDT, TRM_NV5}, '{OP_DIV, 4'd0},
        '{OP_ADDT, TRM_NA5}, '{OP_DIV, 4'd0}, '{OP_DIV, 4'd0}, '{OP_DIV, 4'd0},
        '{OP_HST, 4'd5},
        '{OP_STEPS, 4'd0}, '{OP_END_SEG, 4'd0},
        '{OP_LDC, 4'd5}, '{OP_MUL, 4'd0}, '{OP_ADDC, 4'd4}, '{OP_MUL, 4'd0},
        '{OP_ADDC, 4'd3}, '{OP_MUL, 4'd0}, '{OP_ADDC, 4'd2}, '{OP_MUL, 4'd0},
        '{OP_ADDC, 4'd1}, '{OP_MUL, 4'd0}, '{OP_ADDC, 4'd0}, '{OP_END_TICK, 4'd0}
    };

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       seg_init;
        logic       tick_init;
        logic       hold_out;
        logic       op_en;
        t_op        op;
        logic [3:0] arg;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic dur_zero;
        logic steps_zero;
        logic unit_done;
    } t_stat;

    // saturating add in the coefficient range
    function automatic logic signed [COEF_W-1:0] sat_add(
        input logic signed [COEF_W-1:0] a,
        input logic signed [COEF_W-1:0] b
    );
        logic signed [COEF_W:0] s;
        s = (COEF_W+1)'(a) + (COEF_W+1)'(b);
        if (s > (COEF_W+1)'(SAT_MAX)) begin
            return SAT_MAX;
        end else if (s < (COEF_W+1)'(SAT_MIN)) begin
            return SAT_MIN;
        end
        return s[COEF_W-1:0];
    endfunction

    // give a magnitude its sign back
    function automatic logic signed [COEF_W-1:0] apply_sign(
        input logic             neg,
        input logic [MAG_W-1:0] mag
    );
        logic signed [COEF_W-1:0] v;
        v = $signed({1'b0, mag});
        return neg ? -v : v;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/qtg_div.sv
// ----------------------------------------------------------------------------
// qtg_div
// restoring divider, one quotient bit per cycle, unsigned
// ----------------------------------------------------------------------------
`default_nettype none

module qtg_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [qtg_pkg::DIV_W-1:0]       i_dividend,
    input  wire logic [qtg_pkg::DATA_W-1:0]      i_divisor,
    output logic                                 o_done,
    output logic [qtg_pkg::DIV_W-1:0]            o_quotient
);

    localparam int CNT_W = $clog2(qtg_pkg::DIV_W + 1);

    logic [qtg_pkg::DIV_W-1:0]  r_quo;
    logic [qtg_pkg::DATA_W-1:0] r_rem;
    logic [qtg_pkg::DATA_W-1:0] r_dvs;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_done;

    logic [qtg_pkg::DATA_W:0] w_shift;
    logic [qtg_pkg::DATA_W:0] w_trial;

    // shift in next dividend bit and try a subtract
    assign w_shift = {r_rem, r_quo[qtg_pkg::DIV_W-1]};
    assign w_trial = w_shift - {1'b0, r_dvs};

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(qtg_pkg::DIV_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // partial remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            if (!w_trial[qtg_pkg::DATA_W]) begin
                r_rem <= w_trial[qtg_pkg::DATA_W-1:0];
                r_quo <= {r_quo[qtg_pkg::DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[qtg_pkg::DATA_W-1:0];
                r_quo <= {r_quo[qtg_pkg::DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// File: hw/rtl/qtg_mul.sv
// ----------------------------------------------------------------------------
// qtg_mul
// 63 x 32 unsigned multiplier from two registered partial products (low 32 and high 31 magnitude bits)
// ----------------------------------------------------------------------------
`default_nettype none

module qtg_mul (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [qtg_pkg::MAG_W-1:0]       i_mag,
    input  wire logic [qtg_pkg::DATA_W-1:0]      i_t,
    output logic                                 o_done,
    output logic [qtg_pkg::MUL_W-1:0]            o_product
);

    localparam int HI_W = qtg_pkg::MAG_W - qtg_pkg::DATA_W;

    logic [qtg_pkg::MAG_W-1:0]        r_mag;
    logic [qtg_pkg::DATA_W-1:0]       r_t;
    logic [2*qtg_pkg::DATA_W-1:0]     r_lo;
    logic [HI_W+qtg_pkg::DATA_W-1:0]  r_hi;
    logic [qtg_pkg::MUL_W-1:0]        r_prod;
    logic [1:0]                       r_stage;
    logic                             r_done;

    // stage sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= 2'd0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_stage <= 2'd1;
            end else if (r_stage != 2'd0) begin
                r_stage <= r_stage + 2'd1;
                if (r_stage == 2'd3) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // low half, high half, then combine
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= i_mag;
            r_t   <= i_t;
        end
        if (r_stage == 2'd1) begin
            r_lo <= r_mag[qtg_pkg::DATA_W-1:0] * r_t;
        end
        if (r_stage == 2'd2) begin
            r_hi <= r_mag[qtg_pkg::MAG_W-1:qtg_pkg::DATA_W] * r_t;
        end
        if (r_stage == 2'd3) begin
            r_prod <= {r_hi, {qtg_pkg::DATA_W{1'b0}}} + qtg_pkg::MUL_W'(r_lo);
        end
    end

    assign o_done    = r_done;
    assign o_product = r_prod;

endmodule

`default_nettype wire

// File: hw/rtl/qtg_dp.sv
// ----------------------------------------------------------------------------
// qtg_dp
// datapath: state registers, coefficient file, accumulator, divider, multiplier
// ----------------------------------------------------------------------------
`default_nettype none

module qtg_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire qtg_pkg::t_in                i_in,
    input  wire qtg_pkg::t_cmd               i_cmd,
    input  wire logic                        i_cfg_valid,
    input  wire logic [qtg_pkg::DATA_W-1:0]  i_cfg_data,
    output qtg_pkg::t_stat                   o_stat,
    output qtg_pkg::t_out                    o_out
);

    localparam int CW = qtg_pkg::COEF_W;
    localparam int DW = qtg_pkg::DATA_W;
    localparam int FB = qtg_pkg::FRAC_BITS;
    localparam int TW = qtg_pkg::TERM_W;

    logic signed [DW-1:0] r_s0, r_v0, r_a0;
    logic signed [DW-1:0] r_sf, r_vf, r_af;
    logic [DW-1:0]        r_tf;
    logic [DW-1:0]        r_time_step;
    logic [DW-1:0]        r_time_now;
    logic [DW-1:0]        r_steps;
    logic signed [CW-1:0] r_coef [qtg_pkg::NUM_COEF];
    logic signed [CW-1:0] r_acc;
    qtg_pkg::t_out        r_out;

    logic signed [TW-1:0]      w_ds;
    logic signed [TW-1:0]      w_term;
    logic signed [CW-1:0]      w_term64;
    logic [qtg_pkg::MAG_W-1:0] w_mag;
    logic                      w_div_start;
    logic [qtg_pkg::DIV_W-1:0] w_dividend;
    logic [DW-1:0]             w_divisor;
    logic                      w_div_done;
    logic [qtg_pkg::DIV_W-1:0] w_quo;
    logic                      w_mul_start;
    logic                      w_mul_done;
    logic [qtg_pkg::MUL_W-1:0] w_prod;
    logic                      w_div_sat;
    logic                      w_mul_sat;
    logic signed [CW-1:0]      w_div_res;
    logic signed [CW-1:0]      w_mul_res;
    logic signed [CW-1:0]      w_half;
    logic signed [CW-1:0]      w_rnd;
    logic signed [CW-1:0]      w_shr;
    logic signed [DW-1:0]      w_pos;
    logic [DW:0]               w_tsum;
    logic [2:0]                w_cidx;

    assign w_cidx = i_cmd.arg[2:0];

    // segment terms, each scaled by two; OP_HST halves the result
    always_comb begin
        w_ds = TW'(r_sf) - TW'(r_s0);
        unique case (i_cmd.arg)
            qtg_pkg::TRM_DS20:  w_term = 20 * w_ds;
            qtg_pkg::TRM_NV3:   w_term = -(8 * TW'(r_vf) + 12 * TW'(r_v0));
            qtg_pkg::TRM_NA3:   w_term = -(3 * TW'(r_a0) - TW'(r_af));
            qtg_pkg::TRM_NDS30: w_term = -30 * w_ds;
            qtg_pkg::TRM_V4:    w_term = 14 * TW'(r_vf) + 16 * TW'(r_v0);
            qtg_pkg::TRM_A4:    w_term = 3 * TW'(r_a0) - 2 * TW'(r_af);
            qtg_pkg::TRM_DS12:  w_term = 12 * w_ds;
            qtg_pkg::TRM_NV5:   w_term = -(6 * TW'(r_vf) + 6 * TW'(r_v0));
            qtg_pkg::TRM_NA5:   w_term = -(TW'(r_a0) - TW'(r_af));
            default:            w_term = '0;
        endcase
        w_term64 = {{(CW-TW-FB){w_term[TW-1]}}, w_term, {FB{1'b0}}};
    end

    // accumulator magnitude feeds both units
    assign w_mag = r_acc[CW-1] ? qtg_pkg::MAG_W'(-r_acc) : r_acc[CW-2:0];

    // divider operands: time division or the step count
    assign w_div_start = i_cmd.op_en &&
                         (i_cmd.op == qtg_pkg::OP_DIV || i_cmd.op == qtg_pkg::OP_STEPS);
    assign w_dividend  = (i_cmd.op == qtg_pkg::OP_STEPS) ? qtg_pkg::DIV_W'(r_tf)
                                                         : {1'b0, w_mag, {FB{1'b0}}};
    assign w_divisor   = (i_cmd.op == qtg_pkg::OP_STEPS) ? r_time_step : r_tf;
    assign w_mul_start = i_cmd.op_en && (i_cmd.op == qtg_pkg::OP_MUL);

    qtg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    qtg_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_mag     (w_mag),
        .i_t       (r_time_now),
        .o_done    (w_mul_done),
        .o_product (w_prod)
    );

    // saturate unit results and restore sign
    assign w_div_sat = |w_quo[qtg_pkg::DIV_W-1:qtg_pkg::MAG_W];
    assign w_div_res = qtg_pkg::apply_sign(r_acc[CW-1],
                           w_div_sat ? {qtg_pkg::MAG_W{1'b1}} : w_quo[qtg_pkg::MAG_W-1:0]);
    assign w_mul_sat = |w_prod[qtg_pkg::MUL_W-1:qtg_pkg::MAG_W+FB];
    assign w_mul_res = qtg_pkg::apply_sign(r_acc[CW-1],
                           w_mul_sat ? {qtg_pkg::MAG_W{1'b1}}
                                     : w_prod[qtg_pkg::MAG_W+FB-1:FB]);

    // halve toward zero
    assign w_half = $signed(r_acc + CW'(r_acc[CW-1])) >>> 1;

    // final position: drop fraction toward zero, clamp to 32 bits
    always_comb begin
        w_rnd = r_acc + (r_acc[CW-1] ? CW'((64'd1 << FB) - 64'd1) : CW'(0));
        w_shr = w_rnd >>> FB;
        if (w_shr > CW'(signed'({1'b0, {(DW-1){1'b1}}}))) begin
            w_pos = {1'b0, {(DW-1){1'b1}}};
        end else if (w_shr < -CW'(signed'({1'b0, {(DW-1){1'b1}}})) - 1) begin
            w_pos = {1'b1, {(DW-1){1'b0}}};
        end else begin
            w_pos = w_shr[DW-1:0];
        end
    end

    assign w_tsum = {1'b0, r_time_now} + {1'b0, r_time_step};

    // control state: start state, time, steps, period
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0        <= '0;
            r_v0        <= '0;
            r_a0        <= '0;
            r_time_now  <= '0;
            r_steps     <= '0;
            r_time_step <= DW'(655);
        end else begin
            if (i_cfg_valid) begin
                r_time_step <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_s0    <= i_in.pos;
                r_v0    <= i_in.vel;
                r_a0    <= i_in.acc;
                r_steps <= '0;
            end
            if (i_cmd.tick_init) begin
                r_time_now <= w_tsum[DW] ? {DW{1'b1}} : w_tsum[DW-1:0];
                r_steps    <= r_steps - 1'b1;
            end
            if (w_div_done && i_cmd.op == qtg_pkg::OP_STEPS) begin
                r_steps <= (r_time_step == '0) ? '0 : w_quo[DW-1:0];
            end
            if (i_cmd.op_en && i_cmd.op == qtg_pkg::OP_END_SEG) begin
                r_s0       <= r_sf;
                r_v0       <= r_vf;
                r_a0       <= r_af;
                r_time_now <= '0;
            end
        end
    end

    // payload: targets, coefficients, accumulator, result
    always_ff @(posedge i_clk) begin
        if (i_cmd.seg_init) begin
            r_sf      <= i_in.pos;
            r_vf      <= i_in.vel;
            r_af      <= i_in.acc;
            r_tf      <= i_in.duration;
            r_coef[0] <= CW'(r_s0) <<< FB;
            r_coef[1] <= CW'(r_v0) <<< FB;
            r_coef[2] <= CW'(r_a0) <<< (FB - 1);
            r_coef[3] <= '0;
            r_coef[4] <= '0;
            r_coef[5] <= '0;
        end
        if (i_cmd.hold_out) begin
            r_out.position <= r_s0;
            r_out.moving   <= 1'b0;
        end
        if (w_div_done && i_cmd.op != qtg_pkg::OP_STEPS) begin
            r_acc <= w_div_res;
        end
        if (w_mul_done) begin
            r_acc <= w_mul_res;
        end
        if (i_cmd.op_en) begin
            unique case (i_cmd.op)
                qtg_pkg::OP_LDT:      r_acc <= w_term64;
                qtg_pkg::OP_ADDT:     r_acc <= qtg_pkg::sat_add(r_acc, w_term64);
                qtg_pkg::OP_HST:      r_coef[w_cidx] <= w_half;
                qtg_pkg::OP_LDC:      r_acc <= r_coef[w_cidx];
                qtg_pkg::OP_ADDC:     r_acc <= qtg_pkg::sat_add(r_coef[w_cidx], r_acc);
                qtg_pkg::OP_END_TICK: begin
                    r_out.position <= w_pos;
                    r_out.moving   <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_stat.dur_zero   = (i_in.duration == '0);
    assign o_stat.steps_zero = (r_steps == '0);
    assign o_stat.unit_done  = w_div_done | w_mul_done;
    assign o_out             = r_out;

endmodule

`default_nettype wire

// File: hw/rtl/qtg_ctrl.sv
// ----------------------------------------------------------------------------
// qtg_ctrl
// controller: handshakes and micro-program sequencing
// ----------------------------------------------------------------------------
`default_nettype none

module qtg_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic [1:0]      i_kind,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  wire qtg_pkg::t_stat  i_stat,
    output qtg_pkg::t_cmd        o_cmd
);

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_OUT} t_state;

    t_state                   r_state;
    logic [qtg_pkg::PC_W-1:0] r_pc;
    logic                     r_out_valid;
    qtg_pkg::t_uop            w_uop;
    logic                     w_acc;

    assign w_uop = qtg_pkg::PROG[r_pc];
    assign w_acc = i_in_valid && (r_state == S_IDLE);

    // commands to the datapath
    always_comb begin
        o_cmd           = '0;
        o_cmd.op        = w_uop.op;
        o_cmd.arg       = w_uop.arg;
        o_cmd.op_en     = (r_state == S_ISSUE);
        o_cmd.load      = w_acc && i_kind == qtg_pkg::KIND_LOAD;
        o_cmd.seg_init  = w_acc && i_kind == qtg_pkg::KIND_SEG;
        o_cmd.tick_init = w_acc && i_kind == qtg_pkg::KIND_TICK && !i_stat.steps_zero;
        o_cmd.hold_out  = w_acc && i_kind == qtg_pkg::KIND_TICK && i_stat.steps_zero;
    end

    // state, program counter and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        priority if (i_kind == qtg_pkg::KIND_SEG) begin
                            r_pc    <= i_stat.dur_zero ? qtg_pkg::PC_STEPS : qtg_pkg::PC_SEG;
                            r_state <= S_ISSUE;
                        end else if (i_kind == qtg_pkg::KIND_TICK && i_stat.steps_zero) begin
                            r_out_valid <= 1'b1;
                            r_state     <= S_OUT;
                        end else if (i_kind == qtg_pkg::KIND_TICK) begin
                            r_pc    <= qtg_pkg::PC_TICK;
                            r_state <= S_ISSUE;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_ISSUE: begin
                    unique case (w_uop.op)
                        qtg_pkg::OP_DIV, qtg_pkg::OP_MUL, qtg_pkg::OP_STEPS: begin
                            r_state <= S_WAIT;
                        end
                        qtg_pkg::OP_END_SEG: begin
                            r_state <= S_IDLE;
                        end
                        qtg_pkg::OP_END_TICK: begin
                            r_out_valid <= 1'b1;
                            r_state     <= S_OUT;
                        end
                        default: begin
                            r_pc <= r_pc + 1'b1;
                        end
                    endcase
                end
                S_WAIT: begin
                    if (i_stat.unit_done) begin
                        r_pc    <= r_pc + 1'b1;
                        r_state <= S_ISSUE;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: hw/rtl/quintic_trajectory_generator.sv
// A quintic point-to-point trajectory generator: signed integer positions,
// unsigned Q16.16 times and signed Q47.16 coefficients. One item is taken at a
// time. A tick with no steps left gives its result in the cycle after
// acceptance; a moving tick runs five multiplies, each followed by an addition,
// Horner order; a segment runs twelve time divisions and the step count
// division on one shared restoring divider producing one quotient bit per cycle
// over an 80-bit dividend, and a zero-duration segment only the step count
// division. The time step register is written only while the block is idle.
// ----------------------------------------------------------------------------
// quintic_trajectory_generator
// top level: controller, datapath and handshake ports
// ----------------------------------------------------------------------------
`default_nettype none

`include "quintic_trajectory_generator_assert.svh"

module quintic_trajectory_generator (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire qtg_pkg::t_in                i_in,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output qtg_pkg::t_out                    o_out,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [qtg_pkg::DATA_W-1:0]  i_cfg_data
);

    qtg_pkg::t_cmd  w_cmd;
    qtg_pkg::t_stat w_stat;

    // register write taken only while idle
    assign o_cfg_ready = o_in_ready;

    qtg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_in.kind),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    qtg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (w_stat),
        .o_out       (o_out)
    );

    // one transaction in flight at a time
    `QTG_NEVER(a_one_in_flight, o_in_ready && o_out_valid)
    `QTG_NEXT(a_result_once, o_out_valid && i_out_ready, !o_out_valid)
    `QTG_NEXT(a_tick_busy, i_in_valid && o_in_ready && i_in.kind == qtg_pkg::KIND_TICK, !o_in_ready)

endmodule

`default_nettype wire
